// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Antecedent in a cycle implies the consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uvst_pkg.sv =====
// Package for the unique value set table: field widths, codes and cell commands.
`timescale 1ns / 1ps

package uvst_pkg;

  localparam int VAL_W = 64;
  localparam int OP_W  = 2;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // Commands broadcast to every cell of the row.
  typedef struct packed {
    logic cmp;        // compare the incoming value, register the match
    logic add_wr;     // the cell at the fill mark takes the new value
    logic rem_shift;  // cells from the hit on take their right neighbour
  } cell_cmd_t;

endpackage

// ===== rtl/uvst_in_if.sv =====
// Input channel: operation and value with a valid/ready handshake.
`timescale 1ns / 1ps

interface uvst_in_if import uvst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== rtl/uvst_out_if.sv =====
// Result channel: found, position, count and status with a valid/ready handshake.
`timescale 1ns / 1ps

interface uvst_out_if import uvst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] entry_count;
  logic             status;

  modport source (output valid, output found, output position, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input found, input position, input entry_count,
                  input status, output ready);
endinterface

// ===== rtl/uvst_cell.sv =====
// One table cell: holds an entry, compares it, loads or shifts from its neighbour.
`timescale 1ns / 1ps

module uvst_cell import uvst_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int CELL_IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cell_cmd_t                          cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]      cnt,
  input  logic [$clog2(CAPACITY)-1:0]        hit_idx,
  input  logic [VAL_W-1:0]                   cmp_value,
  input  logic [VAL_W-1:0]                   wr_value,
  input  logic [VAL_W-1:0]                   nb_entry,
  output logic [VAL_W-1:0]                   entry,
  output logic                               match
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] MY_IDX   = CW'(CELL_IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(CELL_IDX + 1);

  logic [VAL_W-1:0] entry_r;
  logic             match_r;
  logic             live;
  logic             past_hit;

  assign live     = MY_IDX < cnt;
  assign past_hit = MY_IDX >= CW'(hit_idx);

  // entry store: no reset, only live cells can ever match
  always_ff @(posedge clk) begin
    if (cmd.add_wr && (MY_IDX == cnt)) begin
      entry_r <= wr_value;
    end else if (cmd.rem_shift && past_hit && (NEXT_IDX < cnt)) begin
      entry_r <= nb_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmd.cmp) begin
      match_r <= live && (entry_r == cmp_value);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ===== rtl/uvst_enc.sv =====
// Match encoder: turns the row of match flags into a hit flag and its index.
`timescale 1ns / 1ps

module uvst_enc import uvst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic [CAPACITY-1:0]         match,
  output logic                        hit,
  output logic [$clog2(CAPACITY)-1:0] hit_idx
);

  localparam int IW = $clog2(CAPACITY);

  // stored values are distinct, so at most one flag is set and an OR suffices
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit = |match;

endmodule

// ===== rtl/unique_value_set_table.sv =====
// Top level of the unique value set table: cell row, encoder, control and result register.
// Path: an accepted input beat has its match flags registered in the cells, then its result
// is loaded into the result register for out_ch. One item at a time (compare, then commit);
//   the commit waits while the result register is held by a stalled sink.
// Reset: synchronous, active low; clears the fill count and the handshake state.
//   Entries have no reset and no clearing pass: only cells below the count are used.
`timescale 1ns / 1ps

module unique_value_set_table import uvst_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  uvst_in_if.sink           in_ch,
  uvst_out_if.source        out_ch
);

`include "assert_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic {S_IDLE, S_RES} state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] value_r;

  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_position_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_status_r;

  logic [VAL_W-1:0]    entry [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic                hit;
  logic [IW-1:0]       hit_idx;

  logic      accept;
  logic      commit;
  logic      full;
  logic      add_ok;
  logic      rem_ok;
  logic [IW-1:0] pos;
  logic [31:0]   pos_ext;
  logic [31:0]   cnt_ext;
  cell_cmd_t cmd;

  // One item at a time: the compare runs at the accept edge, the commit follows once the result register is free.
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // The commit waits for the result register to be free or being emptied.
  assign commit = (state_r == S_RES) && (!out_valid_r || out_ch.ready);

  assign full   = (count_r == CW'(CAPACITY));
  assign add_ok = (op_r == OP_ADD) && !hit && !full;
  assign rem_ok = (op_r == OP_REMOVE) && hit;

  // Broadcast to the row: the compare takes the value straight off the input beat.
  assign cmd.cmp       = accept;
  assign cmd.add_wr    = commit && add_ok;
  assign cmd.rem_shift = commit && rem_ok;

  // Cell row. Each cell sees its right neighbour's entry for the shift on removal;
  // the last cell has none and never shifts, as its successor index is never live.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] nb;
    if (g == CAPACITY - 1) begin : g_last
      assign nb = entry[g];
    end else begin : g_mid
      assign nb = entry[g+1];
    end
    uvst_cell #(
      .CAPACITY (CAPACITY),
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .cnt       (count_r),
      .hit_idx   (hit_idx),
      .cmp_value (in_ch.value),
      .wr_value  (value_r),
      .nb_entry  (nb),
      .entry     (entry[g]),
      .match     (match[g])
    );
  end

  uvst_enc #(
    .CAPACITY (CAPACITY)
  ) u_enc (
    .match   (match),
    .hit     (hit),
    .hit_idx (hit_idx)
  );

  // Position: the hit index, else the fill mark for a fresh add, else zero.
  always_comb begin
    if (hit) begin
      pos = hit_idx;
    end else if (add_ok) begin
      pos = IW'(count_r);
    end else begin
      pos = '0;
    end
  end

  always_comb begin
    if (add_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Result fields are masked to the port widths.
  assign pos_ext = 32'(pos);
  assign cnt_ext = 32'(count_nxt);

  // State, fill count and the result register; the result payload is loaded on commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RES;
          end
        end
        S_RES: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (commit) begin
        count_r        <= count_nxt;
        out_valid_r    <= 1'b1;
        out_found_r    <= hit;
        out_position_r <= pos_ext[POS_W-1:0];
        out_count_r    <= cnt_ext[CNT_W-1:0];
        out_status_r   <= ((op_r == OP_ADD) && !hit && full) ? ST_FULL : ST_OK;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input payload registers, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.operation;
      value_r <= in_ch.value;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.position    = out_position_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.status      = out_status_r;

  // Stored values are distinct, so the compare can never light two cells.
  `ASSERT_ALWAYS(a_single_match, (state_r != S_RES) || $onehot0(match), "two cells matched")
  // The count moves only on a commit.
  `ASSERT_NEXT(a_count_hold, !commit, $stable(count_r), "count changed without a commit")
  // A new result beat appears only out of the commit cycle.
  `ASSERT_ALWAYS(a_result_src, !$rose(out_valid_r) || $past(state_r == S_RES),
                 "result beat without a commit")
  // The fill count stays within the row.
  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "count beyond capacity")

endmodule
